### rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// Golden-section search package
// Shared types, codes and fixed-point constants of the golden-section
// minimum search sequencer.
// ----------------------------------------------------------------------------
package gss_pkg;

	// Widths of points (Q16.16), objective values (Q32.16) and counters.
	localparam int POINT_W = 32;
	localparam int VALUE_W = 48;
	localparam int ITER_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Golden ratio conjugate (sqrt(5)-1)/2 as unsigned Q0.16.
	localparam int PHI_W = 16;
	localparam logic [PHI_W-1:0] PHI_Q16 = 16'd40503;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_BOUND      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BOUND     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 2'd2;

	// Configuration reset values.
	localparam logic signed [POINT_W-1:0] LEFT_BOUND_RST  = -32'sd655360;
	localparam logic signed [POINT_W-1:0] RIGHT_BOUND_RST = 32'sd655360;
	localparam logic [ITER_W-1:0]         ITER_COUNT_RST  = 8'd50;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_VALUE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_PROBE   = 2'd0,
		KIND_ANSWER  = 2'd1,
		KIND_IGNORED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_WAIT_LEFT  = 2'd1,
		PH_WAIT_RIGHT = 2'd2
	} phase_t;

	typedef struct packed {
		action_t                     action;
		logic signed [VALUE_W-1:0]   objective_value;
	} item_t;

	typedef struct packed {
		kind_t                       result_kind;
		logic signed [POINT_W-1:0]   point;
	} result_t;

endpackage

### rtl/gss_offset.sv
// ----------------------------------------------------------------------------
// Golden offset unit
// Scales a signed interval width by phi in Q0.16, rounding the magnitude to
// nearest with halves away from zero and restoring the sign.
// ----------------------------------------------------------------------------
module gss_offset (
	input  logic signed [gss_pkg::POINT_W:0] width,
	output logic signed [gss_pkg::POINT_W:0] offset
);

	localparam int MAG_W  = gss_pkg::POINT_W + 1;
	localparam int PROD_W = MAG_W + gss_pkg::PHI_W;

	logic             neg;
	logic [MAG_W-1:0] mag;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] rounded;
	logic [MAG_W-1:0] scaled;

	assign neg     = width[gss_pkg::POINT_W];
	assign mag     = neg ? MAG_W'(-width) : MAG_W'(width);
	assign prod    = PROD_W'(mag) * PROD_W'(gss_pkg::PHI_Q16);
	assign rounded = prod + (PROD_W'(1) << (gss_pkg::PHI_W - 1));
	// The product of a 33-bit magnitude and phi stays below 2^32 after scaling.
	assign scaled  = rounded[PROD_W-1:gss_pkg::PHI_W];
	assign offset  = neg ? -$signed(scaled) : $signed(scaled);

endmodule

### rtl/golden_section_minimum_search.sv
// ----------------------------------------------------------------------------
// Golden-section minimum search sequencer
// Results: each result is valid the cycle after its item transfer.
// Throughput: one item per cycle; the result register frees in the same cycle
// it is taken, so an item is accepted whenever the result slot is empty or
// being read. Reset: asynchronous active-low; configuration returns to
// [-10.0, +10.0] with 50 iterations, the search goes idle, no result pending.
// ----------------------------------------------------------------------------
module golden_section_minimum_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  gss_pkg::item_t                       item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output gss_pkg::result_t                     result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gss_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int PW = gss_pkg::POINT_W;
	localparam int VW = gss_pkg::VALUE_W;
	localparam int IW = gss_pkg::ITER_W;

	// Configuration registers.
	logic signed [PW-1:0] left_bound_q;
	logic signed [PW-1:0] right_bound_q;
	logic [IW-1:0]        iteration_count_q;

	// Search state: bounds, inner points x1/x2 and their objective values.
	logic signed [PW-1:0] interval_low_q;
	logic signed [PW-1:0] interval_high_q;
	logic signed [PW-1:0] inner_left_q;
	logic signed [PW-1:0] inner_right_q;
	logic signed [VW-1:0] value_left_q;
	logic signed [VW-1:0] value_right_q;
	logic [IW-1:0]        iteration_q;
	gss_pkg::phase_t      phase_q;

	gss_pkg::result_t     result_q;
	logic                 result_valid_q;

	// Next-state values.
	logic signed [PW-1:0] interval_low_d;
	logic signed [PW-1:0] interval_high_d;
	logic signed [PW-1:0] inner_left_d;
	logic signed [PW-1:0] inner_right_d;
	logic signed [VW-1:0] value_left_d;
	logic signed [VW-1:0] value_right_d;
	logic [IW-1:0]        iteration_d;
	gss_pkg::phase_t      phase_d;
	gss_pkg::result_t     result_d;

	logic item_xfer;
	logic busy;
	logic is_start;
	logic first_value;
	logic more_steps;
	logic left_less;

	logic signed [VW-1:0] value_left_eff;
	logic signed [VW-1:0] value_right_eff;
	logic signed [PW-1:0] new_low;
	logic signed [PW-1:0] new_high;
	logic signed [PW:0]   new_width;
	logic signed [PW:0]   golden_t;
	logic signed [PW+1:0] probe_left_wide;
	logic signed [PW+1:0] probe_right_wide;
	logic signed [PW-1:0] probe_left;
	logic signed [PW-1:0] probe_right;
	logic signed [PW:0]   bound_sum;
	logic signed [PW-1:0] midpoint;

	// The result register is the only stall point: a new item may transfer
	// whenever the slot is empty or its result leaves in this same cycle.
	assign item_ready   = !result_valid_q || result_ready;
	assign item_xfer    = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	assign busy        = (phase_q == gss_pkg::PH_WAIT_LEFT) ||
	                     (phase_q == gss_pkg::PH_WAIT_RIGHT);
	assign is_start    = (item.action == gss_pkg::ACT_START);
	assign first_value = (phase_q == gss_pkg::PH_WAIT_LEFT) && (iteration_q == '0);
	assign more_steps  = ({1'b0, iteration_q} + (IW+1)'(1)) < {1'b0, iteration_count_q};

	// The arriving value belongs to whichever inner point was last probed.
	assign value_left_eff  = (phase_q == gss_pkg::PH_WAIT_LEFT) ?
	                         item.objective_value : value_left_q;
	assign value_right_eff = (phase_q == gss_pkg::PH_WAIT_RIGHT) ?
	                         item.objective_value : value_right_q;
	assign left_less       = value_left_eff < value_right_eff;

	// The bounds after this item: latched from configuration on a start,
	// otherwise narrowed toward the smaller value (ties move the left bound).
	always_comb begin
		priority if (is_start) begin
			new_low  = left_bound_q;
			new_high = right_bound_q;
		end else if (left_less) begin
			new_low  = interval_low_q;
			new_high = inner_right_q;
		end else begin
			new_low  = inner_left_q;
			new_high = interval_high_q;
		end
	end

	assign new_width = (PW+1)'(new_high) - (PW+1)'(new_low);

	gss_offset u_offset (
		.width  (new_width),
		.offset (golden_t)
	);

	// Inner points always fall between the bounds, so truncation is exact.
	assign probe_left_wide  = (PW+2)'(new_high) - (PW+2)'(golden_t);
	assign probe_right_wide = (PW+2)'(new_low) + (PW+2)'(golden_t);
	assign probe_left       = probe_left_wide[PW-1:0];
	assign probe_right      = probe_right_wide[PW-1:0];

	// An arithmetic shift of the 33-bit sum gives the floor of the midpoint.
	assign bound_sum = (PW+1)'(new_low) + (PW+1)'(new_high);
	assign midpoint  = bound_sum[PW:1];

	always_comb begin
		interval_low_d   = interval_low_q;
		interval_high_d  = interval_high_q;
		inner_left_d     = inner_left_q;
		inner_right_d    = inner_right_q;
		value_left_d     = value_left_q;
		value_right_d    = value_right_q;
		iteration_d      = iteration_q;
		phase_d          = phase_q;
		result_d.result_kind = gss_pkg::KIND_PROBE;
		result_d.point       = '0;

		priority if (is_start) begin
			// A start drops any search in progress and probes x1 first.
			interval_low_d  = new_low;
			interval_high_d = new_high;
			inner_left_d    = probe_left;
			inner_right_d   = probe_right;
			value_left_d    = '0;
			value_right_d   = '0;
			iteration_d     = '0;
			phase_d         = gss_pkg::PH_WAIT_LEFT;
			result_d.point  = probe_left;
		end else if (!busy) begin
			result_d.result_kind = gss_pkg::KIND_IGNORED;
		end else if (first_value) begin
			// Value at the first x1 is in; ask for the first x2.
			value_left_d   = item.objective_value;
			phase_d        = gss_pkg::PH_WAIT_RIGHT;
			result_d.point = inner_right_q;
		end else if (more_steps) begin
			interval_low_d  = new_low;
			interval_high_d = new_high;
			iteration_d     = iteration_q + IW'(1);
			if (left_less) begin
				// Minimum lies left: old x1 becomes x2, probe a new x1.
				inner_right_d  = inner_left_q;
				inner_left_d   = probe_left;
				value_left_d   = value_left_eff;
				value_right_d  = value_left_eff;
				phase_d        = gss_pkg::PH_WAIT_LEFT;
				result_d.point = probe_left;
			end else begin
				// Minimum lies right: old x2 becomes x1, probe a new x2.
				inner_left_d   = inner_right_q;
				inner_right_d  = probe_right;
				value_left_d   = value_right_eff;
				value_right_d  = value_right_eff;
				phase_d        = gss_pkg::PH_WAIT_RIGHT;
				result_d.point = probe_right;
			end
		end else begin
			// Last narrowing, then answer with the interval midpoint.
			interval_low_d       = new_low;
			interval_high_d      = new_high;
			value_left_d         = value_left_eff;
			value_right_d        = value_right_eff;
			phase_d              = gss_pkg::PH_IDLE;
			result_d.result_kind = gss_pkg::KIND_ANSWER;
			result_d.point       = midpoint;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_bound_q      <= gss_pkg::LEFT_BOUND_RST;
			right_bound_q     <= gss_pkg::RIGHT_BOUND_RST;
			iteration_count_q <= gss_pkg::ITER_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gss_pkg::REG_LEFT_BOUND: begin
					left_bound_q <= $signed(cfg_data[PW-1:0]);
				end
				gss_pkg::REG_RIGHT_BOUND: begin
					right_bound_q <= $signed(cfg_data[PW-1:0]);
				end
				gss_pkg::REG_ITERATION_COUNT: begin
					iteration_count_q <= cfg_data[IW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Search state advances on every item transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_low_q  <= '0;
			interval_high_q <= '0;
			inner_left_q    <= '0;
			inner_right_q   <= '0;
			value_left_q    <= '0;
			value_right_q   <= '0;
			iteration_q     <= '0;
			phase_q         <= gss_pkg::PH_IDLE;
		end else if (item_xfer) begin
			interval_low_q  <= interval_low_d;
			interval_high_q <= interval_high_d;
			inner_left_q    <= inner_left_d;
			inner_right_q   <= inner_right_d;
			value_left_q    <= value_left_d;
			value_right_q   <= value_right_d;
			iteration_q     <= iteration_d;
			phase_q         <= phase_d;
		end
	end

	// Result slot: filled by each item transfer, emptied by a result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_xfer) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			result_q <= result_d;
		end
	end

endmodule

### verif/gss_search_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Golden-section search monitor
// Watches the configuration, item and result channels of the golden-section
// minimum search sequencer. It predicts every result and checks it in order.
// ----------------------------------------------------------------------------
module gss_search_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_ready,
	input  gss_pkg::item_t                 item,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  gss_pkg::result_t               result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [gss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gss_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);

	// Configuration as the block should hold it.
	longint                     bound_left;
	longint                     bound_right;
	logic [gss_pkg::ITER_W-1:0] iter_limit;

	// Search state. Wide integers keep the interval width exact even when
	// the bounds span the whole 32-bit range.
	longint          search_low;
	longint          search_high;
	longint          probe_left;
	longint          probe_right;
	longint          cost_left;
	longint          cost_right;
	int              narrowings;
	gss_pkg::phase_t stage;

	gss_pkg::result_t expected_results[$];

	// Offset of the inner points: span * phi, rounded half away from zero.
	function automatic longint golden_offset(longint span);
		longint unsigned mag;
		longint unsigned t;
		mag = (span < 0) ? -span : span;
		t = (mag * gss_pkg::PHI_Q16 + 64'd32768) >> 16;
		return (span < 0) ? -longint'(t) : longint'(t);
	endfunction

	function automatic gss_pkg::result_t predict_search(gss_pkg::item_t it);
		gss_pkg::result_t r;
		longint  v;
		longint  p;
		logic    left_less;
		v = longint'($signed(it.objective_value));
		p = 0;
		r.result_kind = gss_pkg::KIND_PROBE;
		if (it.action == gss_pkg::ACT_START) begin
			search_low = bound_left;
			search_high = bound_right;
			probe_left = search_high - golden_offset(search_high - search_low);
			probe_right = search_low + golden_offset(search_high - search_low);
			cost_left = 0;
			cost_right = 0;
			narrowings = 0;
			stage = gss_pkg::PH_WAIT_LEFT;
			p = probe_left;
		end else if (stage != gss_pkg::PH_WAIT_LEFT && stage != gss_pkg::PH_WAIT_RIGHT) begin
			r.result_kind = gss_pkg::KIND_IGNORED;
		end else if (stage == gss_pkg::PH_WAIT_LEFT && narrowings == 0) begin
			cost_left = v;
			stage = gss_pkg::PH_WAIT_RIGHT;
			p = probe_right;
		end else begin
			if (stage == gss_pkg::PH_WAIT_LEFT)
				cost_left = v;
			else
				cost_right = v;
			left_less = cost_left < cost_right;
			if (narrowings + 1 < int'(iter_limit)) begin
				if (left_less) begin
					search_high = probe_right;
					probe_right = probe_left;
					cost_right = cost_left;
					probe_left = search_high - golden_offset(search_high - search_low);
					stage = gss_pkg::PH_WAIT_LEFT;
					p = probe_left;
				end else begin
					// Ties land here and move the low bound.
					search_low = probe_left;
					probe_left = probe_right;
					cost_left = cost_right;
					probe_right = search_low + golden_offset(search_high - search_low);
					stage = gss_pkg::PH_WAIT_RIGHT;
					p = probe_right;
				end
				narrowings++;
			end else begin
				if (left_less)
					search_high = probe_right;
				else
					search_low = probe_left;
				// Arithmetic shift gives the floor of the halved sum.
				p = (search_low + search_high) >>> 1;
				r.result_kind = gss_pkg::KIND_ANSWER;
				stage = gss_pkg::PH_IDLE;
			end
		end
		r.point = p[gss_pkg::POINT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gss_pkg::result_t want;
		if (!arst_n) begin
			bound_left = longint'(gss_pkg::LEFT_BOUND_RST);
			bound_right = longint'(gss_pkg::RIGHT_BOUND_RST);
			iter_limit = gss_pkg::ITER_COUNT_RST;
			search_low = 0;
			search_high = 0;
			probe_left = 0;
			probe_right = 0;
			cost_left = 0;
			cost_right = 0;
			narrowings = 0;
			stage = gss_pkg::PH_IDLE;
			expected_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, got kind %0d point %0d",
						$time, result.result_kind, $signed(result.point));
				end else begin
					want = expected_results.pop_front();
					if (result.result_kind !== want.result_kind) begin
						mismatches++;
						$display("%0t: result_kind expected %0d got %0d",
							$time, want.result_kind, result.result_kind);
					end
					if (result.point !== want.point) begin
						mismatches++;
						$display("%0t: point expected %0d got %0d",
							$time, $signed(want.point), $signed(result.point));
					end
				end
			end
			// An item transferred at the same edge as a register write still
			// sees the old register contents.
			if (item_valid && item_ready)
				expected_results.push_back(predict_search(item));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gss_pkg::REG_LEFT_BOUND: bound_left = longint'($signed(cfg_data));
					gss_pkg::REG_RIGHT_BOUND: bound_right = longint'($signed(cfg_data));
					gss_pkg::REG_ITERATION_COUNT: iter_limit = cfg_data[gss_pkg::ITER_W-1:0];
					default: ;
				endcase
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Golden-section minimum search testbench
// Drives start and objective-value transfers into the sequencer, programs the
// search interval and iteration count between searches, and lets a separate
// monitor predict and check every result under varying sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

	// Generous ceiling on the length of a run.
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 375;

	localparam int VW = gss_pkg::VALUE_W;
	localparam int PW = gss_pkg::POINT_W;
	localparam int IW = gss_pkg::ITER_W;

	// Index past the end of the register list; the block must ignore it.
	localparam logic [gss_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic signed [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [PW-1:0] POINT_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic [PW-1:0] POINT_MIN = {1'b1, {(PW-1){1'b0}}};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           item_valid = 1'b0;
	logic                           item_ready;
	gss_pkg::item_t                 item = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	gss_pkg::result_t               result;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [gss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [gss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;

	// Percent chance per cycle that the sender holds off or the receiver stalls.
	int gap_pct = 0;
	int stall_pct = 0;

	// The iteration count last programmed, so that whole searches can be sent.
	logic [IW-1:0] iter_setting = gss_pkg::ITER_COUNT_RST;

	logic signed [VW-1:0] last_objective = '0;
	int cycles = 0;
	int fed;

	golden_section_minimum_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	gss_search_monitor monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random; with stall_pct at zero it always takes.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Hard stop in case the block hangs on a handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("golden_section_minimum_search: mismatch");
			$finish;
		end
	end

	// Offers one item and returns at the edge where it transfers. Valid is
	// left high so that a following item can go out in the very next cycle;
	// it drops only when the sender holds off or waits for the results.
	task automatic send_item(input gss_pkg::action_t act,
			input logic signed [VW-1:0] v);
		if ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{action: act, objective_value: v};
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	// Stops sending and waits until every predicted result has been taken.
	// The monitor's count is registered, so the task waits on the clock first.
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [gss_pkg::CFG_IDX_W-1:0] idx,
			input logic [gss_pkg::CFG_DATA_W-1:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// Writes all three registers back to back, optionally followed by a write
	// to the unused index. Only ever called once every result has been taken.
	task automatic program_search(input logic [PW-1:0] left,
			input logic [PW-1:0] right, input logic [IW-1:0] count,
			input bit junk);
		logic [gss_pkg::CFG_DATA_W-1:0] count_word;
		count_word = $urandom();
		count_word[IW-1:0] = count;
		cfg_valid <= 1'b1;
		write_reg(gss_pkg::REG_LEFT_BOUND, left);
		write_reg(gss_pkg::REG_RIGHT_BOUND, right);
		write_reg(gss_pkg::REG_ITERATION_COUNT, count_word);
		if (junk)
			write_reg(REG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
		iter_setting = count;
	endtask

	// Objective values: many repeats so that ties are common, the extremes,
	// small numbers, and fully random 48-bit patterns.
	function automatic logic signed [VW-1:0] pick_objective();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		case ($urandom_range(7))
			0, 1: ;
			2: last_objective = raw[0] ? VALUE_MAX : VALUE_MIN;
			3, 4: last_objective = {{(VW-12){raw[11]}}, raw[11:0]};
			default: last_objective = raw[VW-1:0];
		endcase
		return last_objective;
	endfunction

	// Values a full search consumes: the second probe, then one per
	// comparison. A zero count acts as one.
	function automatic int search_length();
		return ((iter_setting == 0) ? 1 : int'(iter_setting)) + 1;
	endfunction

	// A start followed by the given number of objective values. The start
	// carries random junk in the value field, which the block must ignore.
	task automatic run_search(input int values);
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		send_item(gss_pkg::ACT_START, raw[VW-1:0]);
		for (int i = 0; i < values; i++)
			send_item(gss_pkg::ACT_VALUE, pick_objective());
		fed += values + 1;
	endtask

	task automatic random_setup();
		logic [PW-1:0] a;
		logic [PW-1:0] b;
		logic [IW-1:0] n;
		case ($urandom_range(5))
			0: begin
				a = $urandom();
				b = $urandom();
			end
			1: begin
				a = -$urandom_range(0, 1 << 20);
				b = $urandom_range(0, 1 << 20);
			end
			2: begin
				a = POINT_MIN;
				b = POINT_MAX;
			end
			3: begin
				a = POINT_MAX;
				b = POINT_MIN;
			end
			4: begin
				a = $urandom();
				b = a;
			end
			default: begin
				a = gss_pkg::LEFT_BOUND_RST;
				b = gss_pkg::RIGHT_BOUND_RST;
			end
		endcase
		// Mostly short searches; the longest and the zero count now and then.
		case ($urandom_range(19))
			0: n = 8'd255;
			1: n = 8'd0;
			2: n = 8'd50;
			default: n = IW'($urandom_range(1, 12));
		endcase
		program_search(a, b, n, $urandom_range(3) == 0);
	endtask

	initial begin
		int gap_tab[4];
		int stall_tab[4];
		int r;
		gap_tab = '{0, 82, 0, 7};
		stall_tab = '{0, 0, 82, 7};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset configuration.
		// A value with no search running is flagged and changes nothing.
		send_item(gss_pkg::ACT_VALUE, VALUE_MAX);
		send_item(gss_pkg::ACT_START, VALUE_MIN);
		send_item(gss_pkg::ACT_VALUE, VALUE_MAX);
		send_item(gss_pkg::ACT_VALUE, VALUE_MIN);
		send_item(gss_pkg::ACT_VALUE, VALUE_MIN);
		send_item(gss_pkg::ACT_VALUE, '0);
		// A start in the middle of a search drops it and begins afresh.
		send_item(gss_pkg::ACT_START, VALUE_MAX);
		send_item(gss_pkg::ACT_VALUE, -48'sd1);
		send_item(gss_pkg::ACT_VALUE, 48'sd1);
		wait_for_results();

		// Widest possible interval and a single iteration; the second value
		// ties the first, so the low bound moves before the answer.
		program_search(POINT_MIN, POINT_MAX, 8'd1, 1'b1);
		send_item(gss_pkg::ACT_START, '0);
		send_item(gss_pkg::ACT_VALUE, 48'sd5);
		send_item(gss_pkg::ACT_VALUE, 48'sd5);
		// Arrives after the answer, so it is flagged.
		send_item(gss_pkg::ACT_VALUE, 48'sd7);
		wait_for_results();

		// Reversed bounds with a zero count, which behaves as one.
		program_search(POINT_MAX, POINT_MIN, 8'd0, 1'b0);
		send_item(gss_pkg::ACT_START, '0);
		send_item(gss_pkg::ACT_VALUE, VALUE_MIN);
		send_item(gss_pkg::ACT_VALUE, VALUE_MAX);
		wait_for_results();

		// Collapsed interval: every probe and the answer sit on one point.
		program_search(32'h0001_0000, 32'h0001_0000, 8'd2, 1'b0);
		send_item(gss_pkg::ACT_START, '0);
		send_item(gss_pkg::ACT_VALUE, 48'sd3);
		send_item(gss_pkg::ACT_VALUE, -48'sd3);
		send_item(gss_pkg::ACT_VALUE, 48'sd0);
		wait_for_results();

		// Random part: four pacing phases, each a mix of whole searches,
		// cut-off searches, stray values and fresh settings.
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = gap_tab[ph];
			stall_pct = stall_tab[ph];
			fed = 0;
			while (fed < ITEMS_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 15) begin
					wait_for_results();
					random_setup();
				end else if (r < 20) begin
					send_item(gss_pkg::ACT_VALUE, pick_objective());
				end else if (r < 28) begin
					run_search($urandom_range(0, search_length() - 1));
				end else if (r < 30) begin
					wait_for_results();
				end else begin
					run_search(search_length());
				end
			end
		end

		stall_pct = 0;
		wait_for_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("golden_section_minimum_search: match");
		else
			$display("golden_section_minimum_search: mismatch");
		$finish;
	end

endmodule

### golden_section_minimum_search.f
rtl/gss_pkg.sv
rtl/gss_offset.sv
rtl/golden_section_minimum_search.sv
verif/gss_search_monitor.sv
verif/testbench.sv
